@@ sv/swsa_pkg.sv @@
package swsa_pkg;

  localparam int CB = 16;
  localparam int FB = CB - 1;
  localparam int UW = CB + 1;
  localparam int PW = 2 * UW + 2;
  localparam int MW = PW + UW;
  localparam int TW = MW + 2;
  localparam int RW = TW - 2 * FB;
  localparam int SB = 24;
  localparam int OB = 24;
  localparam int BW = 16;
  localparam int SCW = MW - 9;
  localparam int LINK_W = 4 * CB;

  localparam logic REG_BETA  = 1'b0;
  localparam logic REG_APPLY = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MULP  = 6'b000010,
    ST_MULT  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    K_P = 2'd0,
    K_T = 2'd1,
    K_S = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] ai;
    logic [1:0] bi;
    logic       neg;
  } qsel_t;

  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [1:0] dest;
    logic       first;
    logic       neg;
  } tag_t;

  // term j of component i of a quaternion product a*b
  function automatic qsel_t qmul_sel(input logic [3:0] step);
    qsel_t s;
    unique case (step)
      4'd0:  s = '{ai: 2'd0, bi: 2'd0, neg: 1'b0};
      4'd1:  s = '{ai: 2'd1, bi: 2'd1, neg: 1'b1};
      4'd2:  s = '{ai: 2'd2, bi: 2'd2, neg: 1'b1};
      4'd3:  s = '{ai: 2'd3, bi: 2'd3, neg: 1'b1};
      4'd4:  s = '{ai: 2'd0, bi: 2'd1, neg: 1'b0};
      4'd5:  s = '{ai: 2'd1, bi: 2'd0, neg: 1'b0};
      4'd6:  s = '{ai: 2'd2, bi: 2'd3, neg: 1'b1};
      4'd7:  s = '{ai: 2'd3, bi: 2'd2, neg: 1'b0};
      4'd8:  s = '{ai: 2'd0, bi: 2'd2, neg: 1'b0};
      4'd9:  s = '{ai: 2'd2, bi: 2'd0, neg: 1'b0};
      4'd10: s = '{ai: 2'd3, bi: 2'd1, neg: 1'b1};
      4'd11: s = '{ai: 2'd1, bi: 2'd3, neg: 1'b0};
      4'd12: s = '{ai: 2'd0, bi: 2'd3, neg: 1'b0};
      4'd13: s = '{ai: 2'd3, bi: 2'd0, neg: 1'b0};
      4'd14: s = '{ai: 2'd1, bi: 2'd2, neg: 1'b1};
      4'd15: s = '{ai: 2'd2, bi: 2'd1, neg: 1'b0};
      default: s = '{ai: 2'd0, bi: 2'd0, neg: 1'b0};
    endcase
    return s;
  endfunction

  // sign-extend one packed component, optionally negate (adjoint of vector part)
  function automatic logic signed [UW-1:0] unpack_comp(input logic [CB-1:0] raw,
                                                       input logic        neg);
    logic signed [UW-1:0] v;
    v = $signed({raw[CB-1], raw});
    return neg ? -v : v;
  endfunction

endpackage

@@ sv/su2_wilson_staple_accumulator.sv @@
// SU(2) Wilson staple accumulator.
// Input channel (in_*): one item is one staple term. tdata carries link_a, link_b
// and link_c as packed Q1.15 quaternions, tuser selects the upper or lower form and
// the conjugate flag, tlast marks the final term of a staple.
// Each term is formed with one shared 36x17 multiplier: 16 products for U1*U2,
// then 16 for the result times U3, a drain after each group, and a step of
// rounding and saturating accumulation. A term that is not the last is worked
// to the end before the next term is accepted; in_tready is high only
// while the block is idle.
// On the last term the sum is moved to the output register (with coupling scaling,
// the same multiplier first forms sum*beta), and the
// accumulator is cleared. Output channel (out_*): tdata carries the four 24-bit
// components, tuser the saturation flag.
// When the receiver stalls, a held result stays in the output register; a
// further term can still be worked, and only the next result waits for the slot.
// Configuration port (cfg_*): index 0 coupling_beta, index 1 apply_coupling,
// always ready; the user must write it only while idle, the block itself does not enforce this.
// Reset clears the accumulator, the saturation flag and the registers to beta 1.0,
// scaling off.
module su2_wilson_staple_accumulator
  import swsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [3*LINK_W-1:0]   in_tdata,   // link_a, link_b, link_c
  input  logic [1:0]            in_tuser,   // command, conjugate
  input  logic                  in_tlast,   // last_term
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [4*OB-1:0]       out_tdata,  // staple_w, staple_x, staple_y, staple_z
  output logic                  out_tuser,  // saturated
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [BW-1:0]         cfg_data
);

  state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  logic signed [UW-1:0] u1_r [4];
  logic signed [UW-1:0] u2_r [4];
  logic signed [UW-1:0] u3_r [4];
  logic conj_r, last_r;

  logic signed [PW-1:0] p_r [4];
  logic signed [TW-1:0] t_r [4];
  logic signed [SB-1:0] sum_r [4];
  logic sticky_r;
  logic signed [OB-1:0] res_r [4];
  logic res_sat_r;

  logic signed [MW-1:0] mul_r;
  tag_t tag_r, tag_nxt;

  logic [BW-1:0] beta_r;
  logic apply_r;

  logic out_tvalid_r, out_sat_r;
  logic [OB-1:0] out_c_r [4];

  logic in_acc, lower, out_free;
  qsel_t sel;
  logic signed [UW-1:0] ua_sel;
  logic signed [SB-1:0] s_sel;
  logic signed [PW-1:0] opa;
  logic signed [UW-1:0] opb;

  logic signed [PW-1:0] mp, p_base, p_new;
  logic signed [TW-1:0] mt, t_base, t_new;
  logic signed [MW-1:0] sc_neg;
  logic signed [SCW-1:0] sc_sh;
  logic signed [OB-1:0] sc_val;
  logic sc_clip;

  logic signed [TW-1:0] tv [4];
  logic signed [TW-1:0] tr [4];
  logic signed [RW-1:0] rt [4];
  logic signed [SB-1:0] term [4];
  logic signed [SB:0]   sw [4];
  logic signed [SB-1:0] sum_new [4];
  logic [3:0] rflag;

  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [OB-1:0] O_MAX = {1'b0, {(OB-1){1'b1}}};
  localparam logic signed [OB-1:0] O_MIN = {1'b1, {(OB-1){1'b0}}};
  localparam logic signed [TW-1:0] RND_HALF = TW'(1) <<< (2 * FB - 1);
  localparam logic signed [MW-1:0] SC_HALF = MW'(256);

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign lower      = in_tuser[0];
  assign cfg_ready  = 1'b1;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_sat_r;
  assign out_tdata  = {out_c_r[3], out_c_r[2], out_c_r[1], out_c_r[0]};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_MULP;
          cnt_nxt   = '0;
        end
      end
      ST_MULP: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r[4]) begin
          state_nxt = ST_MULT;
          cnt_nxt   = '0;
        end
      end
      ST_MULT: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r[4]) begin
          state_nxt = ST_ROUND;
          cnt_nxt   = '0;
        end
      end
      ST_ROUND: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (apply_r) begin
          state_nxt = ST_SCALE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCALE: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r[2]) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    sel    = qmul_sel(cnt_r[3:0]);
    ua_sel = u1_r[sel.ai];
    s_sel  = sum_r[cnt_r[1:0]];
    opa    = {{(PW-UW){ua_sel[UW-1]}}, ua_sel};
    opb    = u2_r[sel.bi];
    tag_nxt = '{vld: 1'b0, kind: K_P, dest: cnt_r[3:2], first: (cnt_r[1:0] == 2'd0),
                neg: sel.neg};
    unique case (state_r)
      ST_MULP: begin
        tag_nxt.vld = !cnt_r[4];
      end
      ST_MULT: begin
        opa          = p_r[sel.ai];
        opb          = u3_r[sel.bi];
        tag_nxt.vld  = !cnt_r[4];
        tag_nxt.kind = K_T;
      end
      ST_SCALE: begin
        opa          = {{(PW-SB){s_sel[SB-1]}}, s_sel};
        opb          = $signed({{(UW-BW){1'b0}}, beta_r});
        tag_nxt.vld  = !cnt_r[2];
        tag_nxt.kind = K_S;
        tag_nxt.dest = cnt_r[1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= opa * opb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  // accumulate registered products
  always_comb begin
    mp     = mul_r[PW-1:0];
    p_base = tag_r.first ? '0 : p_r[tag_r.dest];
    p_new  = tag_r.neg ? p_base - mp : p_base + mp;
    mt     = {{(TW-MW){mul_r[MW-1]}}, mul_r};
    t_base = tag_r.first ? '0 : t_r[tag_r.dest];
    t_new  = tag_r.neg ? t_base - mt : t_base + mt;
    sc_neg = SC_HALF - mul_r;
    sc_sh  = sc_neg[MW-1:9];
    sc_clip = 1'b0;
    sc_val  = sc_sh[OB-1:0];
    if (!sc_sh[SCW-1] && (|sc_sh[SCW-2:OB-1])) begin
      sc_val  = O_MAX;
      sc_clip = 1'b1;
    end else if (sc_sh[SCW-1] && !(&sc_sh[SCW-2:OB-1])) begin
      sc_val  = O_MIN;
      sc_clip = 1'b1;
    end
  end

  // rounding and saturating accumulation of the four components
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tv[k] = (conj_r && (k != 0)) ? -t_r[k] : t_r[k];
      tr[k] = tv[k] + RND_HALF;
      rt[k] = tr[k][TW-1:2*FB];
      rflag[k] = 1'b0;
      term[k] = rt[k][SB-1:0];
      if (!rt[k][RW-1] && (|rt[k][RW-2:SB-1])) begin
        term[k]  = S_MAX;
        rflag[k] = 1'b1;
      end else if (rt[k][RW-1] && !(&rt[k][RW-2:SB-1])) begin
        term[k]  = S_MIN;
        rflag[k] = 1'b1;
      end
      sw[k] = {sum_r[k][SB-1], sum_r[k]} + {term[k][SB-1], term[k]};
      sum_new[k] = sw[k][SB-1:0];
      if (sw[k][SB] != sw[k][SB-1]) begin
        sum_new[k] = sw[k][SB] ? S_MIN : S_MAX;
        rflag[k]   = 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < 4; k++) begin
        u1_r[k] <= unpack_comp(in_tdata[k*CB +: CB], lower && (k != 0));
        u2_r[k] <= unpack_comp(in_tdata[LINK_W + k*CB +: CB], k != 0);
        u3_r[k] <= unpack_comp(in_tdata[2*LINK_W + k*CB +: CB], !lower && (k != 0));
      end
      conj_r <= in_tuser[1];
      last_r <= in_tlast;
    end
    if (tag_r.vld) begin
      unique case (tag_r.kind)
        K_P: p_r[tag_r.dest] <= p_new;
        K_T: t_r[tag_r.dest] <= t_new;
        K_S: res_r[tag_r.dest] <= sc_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_sat_r <= 1'b0;
    end else if (state_r == ST_ROUND) begin
      res_sat_r <= 1'b0;
    end else if (tag_r.vld && (tag_r.kind == K_S) && sc_clip) begin
      res_sat_r <= 1'b1;
    end
  end

  // accumulator and saturation flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        sum_r[k] <= '0;
      end
      sticky_r <= 1'b0;
    end else if (state_r == ST_ROUND) begin
      for (int k = 0; k < 4; k++) begin
        sum_r[k] <= sum_new[k];
      end
      sticky_r <= sticky_r | (|rflag);
    end else if ((state_r == ST_EMIT) && out_free) begin
      for (int k = 0; k < 4; k++) begin
        sum_r[k] <= '0;
      end
      sticky_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == ST_EMIT) && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && out_free) begin
      for (int k = 0; k < 4; k++) begin
        out_c_r[k] <= apply_r ? res_r[k] : sum_r[k];
      end
      out_sat_r <= sticky_r | (apply_r & res_sat_r);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r  <= BW'(256);
      apply_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BETA:  beta_r  <= cfg_data;
        REG_APPLY: apply_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
